// ===== design/adjacent_line_dedup_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adjacent line dedup unit
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ADJACENT_LINE_DEDUP_UNIT_ASSERT_SVH
`define ADJACENT_LINE_DEDUP_UNIT_ASSERT_SVH

// Checked only outside reset.
`define ALDU_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ALDU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/aldu_pkg.sv =====
// ----------------------------------------------------------------------------
// aldu_pkg
// Types and constants shared by the adjacent line dedup unit.
// ----------------------------------------------------------------------------
package aldu_pkg;

  localparam int LINE_MAX_DEF = 4096;
  localparam int RESULT_FIFO_DEPTH = 8;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic [1:0] REG_FIELDS_TO_SKIP   = 2'd0;
  localparam logic [1:0] REG_LETTERS_TO_SKIP  = 2'd1;
  localparam logic [1:0] REG_LETTERS_TO_CHECK = 2'd2;
  localparam logic [1:0] REG_FILTER_MODE      = 2'd3;

  localparam logic [1:0] FILTER_SINGLE   = 2'd1;
  localparam logic [1:0] FILTER_REPEATED = 2'd2;

  typedef enum logic [3:0] {
    PH_BLANK  = 4'b0001,
    PH_WORD   = 4'b0010,
    PH_LETTER = 4'b0100,
    PH_KEY    = 4'b1000
  } aldu_phase_t;

  typedef struct packed {
    logic [7:0]  fields_to_skip;
    logic [11:0] letters_to_skip;
    logic [11:0] letters_to_check;
    logic [1:0]  filter_mode;
  } aldu_cfg_t;

  // One accepted word as it leaves the scanner.
  typedef struct packed {
    logic       eoi;
    logic       close;
    logic       partial;
    logic       cmp_en;
    logic [7:0] data;
  } aldu_item_t;

  typedef struct packed {
    logic [31:0] first_line;
    logic [15:0] repeat_count;
    logic        last_result;
  } aldu_result_t;

  typedef struct packed {
    logic         v0;
    logic         v1;
    aldu_result_t r0;
    aldu_result_t r1;
  } aldu_push_t;

  typedef struct packed {
    logic open;
    logic bank;
  } aldu_status_t;

endpackage

// ===== design/aldu_ram.sv =====
// ----------------------------------------------------------------------------
// aldu_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module aldu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/aldu_scan.sv =====
// ----------------------------------------------------------------------------
// aldu_scan
// Line scanner: skips fields and letters, addresses the key memory.
// ----------------------------------------------------------------------------
module aldu_scan #(
  parameter int LINE_MAX = aldu_pkg::LINE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [7:0]                      byte_in,
  input  logic                            end_of_input,
  input  aldu_pkg::aldu_cfg_t             cfg,
  input  aldu_pkg::aldu_status_t          status,
  input  logic [$clog2(LINE_MAX+1)-1:0]   klen_ob,
  output aldu_pkg::aldu_item_t            item,
  output logic [$clog2(LINE_MAX+1)-1:0]   newlen,
  output logic                            mem_we,
  output logic [$clog2(2*LINE_MAX)-1:0]   mem_waddr,
  output logic [$clog2(2*LINE_MAX)-1:0]   mem_raddr
);
  import aldu_pkg::*;

  localparam int KW = $clog2(LINE_MAX + 1);
  localparam int PW = $clog2(LINE_MAX);
  localparam int AW = $clog2(2 * LINE_MAX);
  localparam int CW = (KW > 12) ? KW : 12;

  aldu_phase_t   phase, phase_next;
  logic [7:0]    fields_skipped, fields_next;
  logic [11:0]   letters_skipped, letters_next;
  logic [KW-1:0] key_index, key_next;
  logic [PW-1:0] line_position, pos_next;

  logic blank, key_byte, in_range, write_bank, close;

  always_comb begin
    logic done;
    blank        = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
    phase_next   = phase;
    fields_next  = fields_skipped;
    letters_next = letters_skipped;
    key_byte     = 1'b0;
    done         = 1'b0;
    for (int g = 0; g < 4; g++) begin
      if (!done) begin
        unique case (phase_next)
          PH_BLANK: begin
            if (fields_next >= cfg.fields_to_skip) begin
              phase_next = PH_LETTER;
            end else begin
              if (!blank) phase_next = PH_WORD;
              done = 1'b1;
            end
          end
          PH_WORD: begin
            if (!blank) begin
              done = 1'b1;
            end else begin
              fields_next = fields_next + 8'd1;
              phase_next  = PH_BLANK;
            end
          end
          PH_LETTER: begin
            if (letters_next >= cfg.letters_to_skip) begin
              phase_next = PH_KEY;
            end else begin
              letters_next = letters_next + 12'd1;
              done = 1'b1;
            end
          end
          PH_KEY: begin
            key_byte = 1'b1;
            done     = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
    end
  end

  assign in_range   = key_byte && (key_index < KW'(LINE_MAX));
  assign key_next   = in_range ? key_index + KW'(1) : key_index;
  assign pos_next   = line_position + PW'(1);
  assign close      = (byte_in == CH_NEWLINE) || (pos_next >= PW'(LINE_MAX - 1));
  assign write_bank = status.open ? ~status.bank : status.bank;

  assign mem_we    = take && !end_of_input && in_range;
  assign mem_waddr = write_bank ? AW'(LINE_MAX) + AW'(key_index) : AW'(key_index);
  assign mem_raddr = status.bank ? AW'(LINE_MAX) + AW'(key_index) : AW'(key_index);

  assign item.eoi     = end_of_input;
  assign item.close   = !end_of_input && close;
  assign item.partial = (line_position != '0);
  assign item.cmp_en  = !end_of_input && in_range && status.open &&
                        ((cfg.letters_to_check == '0) ||
                         (CW'(key_index) < CW'(cfg.letters_to_check))) &&
                        (key_index < klen_ob);
  assign item.data    = byte_in;
  assign newlen       = end_of_input ? key_index : key_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BLANK;
      fields_skipped  <= '0;
      letters_skipped <= '0;
      key_index       <= '0;
      line_position   <= '0;
    end else if (take) begin
      if (end_of_input || close) begin
        phase           <= PH_BLANK;
        fields_skipped  <= '0;
        letters_skipped <= '0;
        key_index       <= '0;
        line_position   <= '0;
      end else begin
        phase           <= phase_next;
        fields_skipped  <= fields_next;
        letters_skipped <= letters_next;
        key_index       <= key_next;
        line_position   <= pos_next;
      end
    end
  end

endmodule

// ===== design/aldu_group.sv =====
// ----------------------------------------------------------------------------
// aldu_group
// Group tracker: finishes the key compare and closes lines and groups.
// ----------------------------------------------------------------------------
module aldu_group #(
  parameter int LINE_MAX = aldu_pkg::LINE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  aldu_pkg::aldu_item_t          item_in,
  input  logic [$clog2(LINE_MAX+1)-1:0] newlen_in,
  input  logic [7:0]                    rdata,
  input  aldu_pkg::aldu_cfg_t           cfg,
  output aldu_pkg::aldu_status_t        status,
  output logic [$clog2(LINE_MAX+1)-1:0] klen_ob,
  output logic                          busy,
  output aldu_pkg::aldu_push_t          push
);
  import aldu_pkg::*;

  localparam int KW = $clog2(LINE_MAX + 1);
  localparam int CW = (KW > 12) ? KW : 12;

  aldu_item_t    item;
  logic          item_valid;
  logic [KW-1:0] newlen;
  logic [KW-1:0] key_length [2];

  logic          group_bank, group_open, key_differs;
  logic [15:0]   group_size;
  logic [31:0]   group_start_line, line_number;

  logic          bank_next, open_next, differs_next, klen_we;
  logic [15:0]   size_next;
  logic [31:0]   start_next, line_next;

  function automatic logic [CW-1:0] cut_length(input logic [KW-1:0] len,
                                               input logic [11:0] check);
    logic [CW-1:0] l;
    l = CW'(len);
    if ((check != '0) && (l > CW'(check))) return CW'(check);
    return l;
  endfunction

  function automatic logic filter_ok(input logic [1:0] mode, input logic [15:0] count);
    logic ok;
    ok = 1'b1;
    if ((mode == FILTER_SINGLE) && (count > 16'd1)) ok = 1'b0;
    if ((mode == FILTER_REPEATED) && (count <= 16'd1)) ok = 1'b0;
    return ok;
  endfunction

  assign status.open = group_open;
  assign status.bank = group_bank;
  assign klen_ob     = key_length[group_bank];
  assign busy        = item_valid && (item.close || item.eoi);

  always_comb begin
    logic do_close, dcur, emit_a, emit_b;
    logic [31:0] first_a;
    logic [15:0] count_a;
    dcur         = key_differs || (item.cmp_en && (rdata != item.data));
    do_close     = item.close || (item.eoi && item.partial);
    bank_next    = group_bank;
    open_next    = group_open;
    size_next    = group_size;
    start_next   = group_start_line;
    line_next    = line_number;
    differs_next = dcur;
    klen_we      = 1'b0;
    emit_a       = 1'b0;
    emit_b       = 1'b0;
    first_a      = group_start_line;
    count_a      = group_size;
    if (item_valid) begin
      if (do_close) begin
        differs_next = 1'b0;
        if (!group_open) begin
          open_next  = 1'b1;
          size_next  = 16'd1;
          start_next = line_number;
          klen_we    = 1'b1;
        end else if (!dcur && (cut_length(newlen, cfg.letters_to_check) ==
                               cut_length(key_length[group_bank], cfg.letters_to_check))) begin
          if (group_size != 16'hffff) size_next = group_size + 16'd1;
        end else begin
          emit_a     = filter_ok(cfg.filter_mode, group_size);
          bank_next  = ~group_bank;
          klen_we    = 1'b1;
          start_next = line_number;
          size_next  = 16'd1;
        end
        line_next = line_number + 32'd1;
      end
      if (item.eoi) begin
        emit_b       = open_next && filter_ok(cfg.filter_mode, size_next);
        push.r1.first_line = start_next;
        differs_next = 1'b0;
      end
    end
    push.v0                 = emit_a || emit_b;
    push.v1                 = emit_a && emit_b;
    push.r0.first_line      = emit_a ? first_a : start_next;
    push.r0.repeat_count    = emit_a ? count_a : size_next;
    push.r0.last_result     = !(emit_a && emit_b);
    push.r1.first_line      = start_next;
    push.r1.repeat_count    = size_next;
    push.r1.last_result     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item   <= item_in;
      newlen <= newlen_in;
    end
    if (item_valid && klen_we) begin
      key_length[bank_next] <= newlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid       <= 1'b0;
      group_bank       <= 1'b0;
      group_open       <= 1'b0;
      group_size       <= '0;
      group_start_line <= '0;
      line_number      <= '0;
      key_differs      <= 1'b0;
    end else begin
      item_valid  <= take;
      group_bank  <= bank_next;
      key_differs <= item_valid ? differs_next : key_differs;
      if (item_valid && item.eoi) begin
        group_open       <= 1'b0;
        group_size       <= '0;
        group_start_line <= '0;
        line_number      <= '0;
      end else begin
        group_open       <= open_next;
        group_size       <= size_next;
        group_start_line <= start_next;
        line_number      <= line_next;
      end
    end
  end

endmodule

// ===== design/aldu_outq.sv =====
// ----------------------------------------------------------------------------
// aldu_outq
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module aldu_outq #(
  parameter int DEPTH = aldu_pkg::RESULT_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aldu_pkg::aldu_push_t  push,
  input  logic                  out_stall,
  output logic                  out_valid,
  output aldu_pkg::aldu_result_t head,
  output logic                  room
);
  import aldu_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  aldu_result_t   entries [DEPTH];
  logic [IW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0] count;
  logic           pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for the four results that an accepted word and the word ahead of it may still cause.
  assign room      = (count <= CNW'(DEPTH - 4));

  always_ff @(posedge clk) begin
    if (push.v0) entries[wr_ptr] <= push.r0;
    if (push.v1) entries[IW'(wr_ptr + IW'(1))] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + IW'(push.v0) + IW'(push.v1);
      rd_ptr <= rd_ptr + IW'(pop);
      count  <= count + CNW'(push.v0) + CNW'(push.v1) - CNW'(pop);
    end
  end

  `include "adjacent_line_dedup_unit_assert.svh"
  `ALDU_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0), "queue not empty after reset")
  `ALDU_ASSERT_RUN(a_bound, count <= CNW'(DEPTH), "queue count beyond depth")
  `ALDU_ASSERT_RUN(a_pair, push.v1 |-> push.v0, "second result without first")
  `ALDU_ASSERT_RUN(a_no_over, push.v1 |-> (count <= CNW'(DEPTH - 2)), "queue overflow")

endmodule

// ===== design/adjacent_line_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// A word passes the group stage's item register, and its results the result queue, before out_valid.
// Throughput: one word per cycle, but the input stalls while a line end or
//   end of input is in the group stage, for its key-length and bank update.
// The input also stalls while the result queue holds more than four results.
// Reset (rst, synchronous) clears control state; the key memory is not cleared.
// ----------------------------------------------------------------------------
// adjacent_line_dedup_unit
// Adjacent duplicate line filter. The scanner finds each line's key and
// writes it into one bank of a ping-pong key memory while it reads the
// same position of the group's first key from the other bank. The group
// stage finishes the byte compare in the next cycle, when the read data is
// back, and closes lines and groups. Group reports go through a small
// queue so that the input keeps flowing while the consumer stalls.
// ----------------------------------------------------------------------------
module adjacent_line_dedup_unit #(
  parameter int LINE_MAX = aldu_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] first_line,
  output logic [15:0] repeat_count,
  output logic        last_result
);
  import aldu_pkg::*;

  localparam int KW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(2 * LINE_MAX);

  aldu_cfg_t     cfg;
  aldu_status_t  status;
  aldu_item_t    item;
  aldu_push_t    push;
  aldu_result_t  head;
  logic [KW-1:0] klen_ob, newlen;
  logic          take, busy, room, mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    rdata;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FIELDS_TO_SKIP:   cfg.fields_to_skip   <= cfg_data[7:0];
        REG_LETTERS_TO_SKIP:  cfg.letters_to_skip  <= cfg_data;
        REG_LETTERS_TO_CHECK: cfg.letters_to_check <= cfg_data;
        REG_FILTER_MODE:      cfg.filter_mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A line end in the group stage changes the bank and key length that the
  // scanner uses, so the next word waits while that line end is in the group stage.
  assign in_stall = busy || !room;
  assign take     = in_valid && !in_stall;

  aldu_scan #(.LINE_MAX(LINE_MAX)) u_scan (
    .clk, .rst, .take, .byte_in, .end_of_input, .cfg, .status, .klen_ob,
    .item, .newlen, .mem_we, .mem_waddr, .mem_raddr
  );

  // Both key banks live in one memory: bank b holds entries b*LINE_MAX on.
  aldu_ram #(.WIDTH(8), .DEPTH(2 * LINE_MAX)) u_key_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(byte_in),
    .re(take), .raddr(mem_raddr), .rdata
  );

  aldu_group #(.LINE_MAX(LINE_MAX)) u_group (
    .clk, .rst, .take, .item_in(item), .newlen_in(newlen), .rdata, .cfg,
    .status, .klen_ob, .busy, .push
  );

  aldu_outq #(.DEPTH(RESULT_FIFO_DEPTH)) u_outq (
    .clk, .rst, .push, .out_stall, .out_valid, .head, .room
  );

  assign first_line   = head.first_line;
  assign repeat_count = head.repeat_count;
  assign last_result  = head.last_result;

endmodule

// ===== tb/tb_adjacent_line_dedup_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the adjacent line dedup unit
// Drives byte streams and end-of-input words into the block and checks each
// group report against a typed expectation or a behavioral copy of the line grouping kept here.
// ----------------------------------------------------------------------------
module tb_adjacent_line_dedup_unit;
  import aldu_pkg::*;

  localparam int LMAX      = LINE_MAX_DEF;
  localparam int CYCLE_CAP = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  byte_in;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] first_line;
  logic [15:0] repeat_count;
  logic        last_result;

  adjacent_line_dedup_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .byte_in(byte_in), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_line(first_line), .repeat_count(repeat_count),
    .last_result(last_result)
  );

  // Clock, plus a free-running cycle count that also acts as the watchdog.
  int unsigned cycles;
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Line grouping predictor. It mirrors the register settings and the whole
  // grouping state, including both banks of the key memory.
  // --------------------------------------------------------------------------
  aldu_cfg_t     regs;
  logic [7:0]    key_mem [2*LMAX];
  int unsigned   key_len [2];
  logic          grp_bank, grp_open;
  int unsigned   grp_size;
  logic [31:0]   grp_first, line_no;
  int unsigned   line_pos, words_done, letters_done, key_pos;
  aldu_phase_t   scan;
  logic          mismatch_seen;

  aldu_result_t  pending_groups [$];
  int            errors = 0;

  function automatic void clear_line_state();
    line_pos = 0;
    scan = PH_BLANK;
    words_done = 0;
    letters_done = 0;
    key_pos = 0;
    mismatch_seen = 1'b0;
  endfunction

  function automatic void reset_model();
    regs = '0;
    key_len[0] = 0;
    key_len[1] = 0;
    grp_bank = 1'b0;
    grp_open = 1'b0;
    grp_size = 0;
    grp_first = '0;
    line_no = '0;
    clear_line_state();
  endfunction

  function automatic int unsigned clip_len(int unsigned len);
    if (regs.letters_to_check != 0 && len > regs.letters_to_check)
      return regs.letters_to_check;
    return len;
  endfunction

  // A group report, dropped when the filter mode rejects its size.
  function automatic void report_group(ref aldu_result_t r[2], ref int n,
                                       input logic [31:0] first,
                                       input int unsigned count);
    if (regs.filter_mode == FILTER_SINGLE && count > 1) return;
    if (regs.filter_mode == FILTER_REPEATED && count <= 1) return;
    if (n >= 2) return;
    r[n].first_line = first;
    r[n].repeat_count = count[15:0];
    r[n].last_result = 1'b0;
    n++;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic blank;
    logic wb;
    logic ob;
    blank = (b == CH_SPACE || b == CH_TAB);
    wb = grp_open ? ~grp_bank : grp_bank;
    ob = grp_bank;
    for (int g = 0; g < 4; g++) begin
      case (scan)
        PH_BLANK: begin
          if (words_done >= regs.fields_to_skip) begin
            scan = PH_LETTER;
            continue;
          end
          if (!blank) scan = PH_WORD;
          return;
        end
        PH_WORD: begin
          if (!blank) return;
          words_done++;
          scan = PH_BLANK;
          continue;
        end
        PH_LETTER: begin
          if (letters_done >= regs.letters_to_skip) begin
            scan = PH_KEY;
            continue;
          end
          letters_done++;
          return;
        end
        default: begin
          if (key_pos < LMAX) begin
            key_mem[wb*LMAX + key_pos] = b;
            if (grp_open && (regs.letters_to_check == 0 || key_pos < regs.letters_to_check))
              if (key_pos < key_len[ob] && key_mem[ob*LMAX + key_pos] != b)
                mismatch_seen = 1'b1;
            key_pos++;
          end
          return;
        end
      endcase
    end
  endfunction

  function automatic void close_line(ref aldu_result_t r[2], ref int n);
    if (!grp_open) begin
      grp_open = 1'b1;
      grp_size = 1;
      grp_first = line_no;
      key_len[grp_bank] = key_pos;
    end else if (!mismatch_seen && clip_len(key_pos) == clip_len(key_len[grp_bank])) begin
      if (grp_size < 16'hffff) grp_size++;
    end else begin
      report_group(r, n, grp_first, grp_size);
      grp_bank = ~grp_bank;
      key_len[grp_bank] = key_pos;
      grp_first = line_no;
      grp_size = 1;
    end
    line_no = line_no + 1;
    clear_line_state();
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic eoi,
                                       output aldu_result_t r[2], output int n);
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (eoi) begin
      if (line_pos > 0) close_line(r, n);
      if (grp_open) report_group(r, n, grp_first, grp_size);
      grp_open = 1'b0;
      grp_size = 0;
      grp_first = '0;
      line_no = '0;
      clear_line_state();
    end else begin
      scan_byte(b);
      line_pos++;
      if (b == CH_NEWLINE || line_pos >= LMAX - 1) close_line(r, n);
    end
    if (n > 0) r[n-1].last_result = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. A word is offered from a falling edge and held until a rising
  // edge sees in_stall low. Valid stays up until the next word or an idle
  // cycle replaces it at a later falling edge.
  // --------------------------------------------------------------------------
  logic idle_on;       // random gaps and stalls enabled
  logic hold_request;  // asks the receiver for one long hold-off

  task automatic send_word(input logic [7:0] b, input logic eoi,
                           input int typed_n = -1,
                           input aldu_result_t t0 = '0, input aldu_result_t t1 = '0);
    aldu_result_t r[2];
    int n;
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    predict_word(b, eoi, r, n);
    // Directed rows carry their own expectation; the predictor still runs so
    // that its state keeps up with the stream.
    if (typed_n >= 0) begin
      n = typed_n;
      r[0] = t0;
      r[1] = t1;
    end
    for (int i = 0; i < n; i++) pending_groups.push_back(r[i]);
    @(negedge clk);
  endtask

  // Drops valid, waits until every report has come out, then lets the
  // pipeline drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_FIELDS_TO_SKIP:   regs.fields_to_skip = val[7:0];
      REG_LETTERS_TO_SKIP:  regs.letters_to_skip = val;
      REG_LETTERS_TO_CHECK: regs.letters_to_check = val;
      REG_FILTER_MODE:      regs.filter_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned f, input int unsigned ls,
                          input int unsigned lc, input int unsigned fm);
    write_reg(REG_FIELDS_TO_SKIP, 12'(f));
    write_reg(REG_LETTERS_TO_SKIP, 12'(ls));
    write_reg(REG_LETTERS_TO_CHECK, 12'(lc));
    write_reg(REG_FILTER_MODE, 12'(fm));
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return (p < 20) ? 8'h61 : 8'h62;
    if (p < 62) return CH_SPACE;
    if (p < 72) return CH_TAB;
    return 8'($urandom_range(255));
  endfunction

  // Random lines, mostly repeats of the previous line so that groups form,
  // with an occasional flipped byte, missing newline or end of input.
  task automatic random_stream(input int word_budget);
    logic [7:0] prev [$];
    logic [7:0] cur [$];
    int sent;
    sent = 0;
    while (sent < word_budget) begin
      if (prev.size() != 0 && $urandom_range(99) < 55) begin
        cur = prev;
        if (cur.size() != 0 && $urandom_range(99) < 20)
          cur[$urandom_range(cur.size()-1)] = pick_byte();
      end else begin
        cur.delete();
        repeat ($urandom_range(10)) cur.push_back(pick_byte());
      end
      foreach (cur[i]) send_word(cur[i], 1'b0);
      sent += cur.size() + 1;
      if ($urandom_range(99) < 8) begin
        send_word(8'($urandom_range(255)), 1'b1);
        prev.delete();
      end else begin
        send_word(CH_NEWLINE, 1'b0);
        prev = cur;
      end
    end
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Directed rows: typed expectations where they follow directly from the
  // reset settings, predictor elsewhere (count of -1).
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0] b;
    logic       eoi;
    int         n;
    logic [31:0] f0;
    logic [15:0] c0;
    logic [31:0] f1;
    logic [15:0] c1;
  } stim_row_t;

  stim_row_t rows [] = '{
    '{8'h61, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  0, 0, 0, 0, 0},   // first line only opens a group
    '{8'h61, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  0, 0, 0, 0, 0},   // duplicate grows the group
    '{8'h62, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  1, 0, 2, 0, 0},
    '{8'h00, 1'b0, -1, 0, 0, 0, 0},   // zero byte is plain text
    '{8'h0a, 1'b0,  1, 2, 1, 0, 0},
    '{8'hff, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  1, 3, 1, 0, 0},
    '{8'h20, 1'b0, -1, 0, 0, 0, 0},
    '{8'h09, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  1, 4, 1, 0, 0},
    '{8'h55, 1'b1,  1, 5, 1, 0, 0},   // end of input closes the last group
    '{8'haa, 1'b1,  0, 0, 0, 0, 0},   // end of input with no data
    '{8'h78, 1'b0, -1, 0, 0, 0, 0},
    '{8'h0a, 1'b0,  0, 0, 0, 0, 0},
    '{8'h79, 1'b0, -1, 0, 0, 0, 0},
    '{8'h00, 1'b1,  2, 0, 1, 1, 1}    // partial line closes, then its group
  };

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request, and the checker.
  // --------------------------------------------------------------------------
  int hold_left;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    aldu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_groups.size() == 0) begin
        $display("%0t: report with none expected: first_line %0d repeat_count %0d",
                 $time, first_line, repeat_count);
        errors++;
      end else begin
        want = pending_groups.pop_front();
        if (first_line !== want.first_line) begin
          $display("%0t: first_line expected %0d actual %0d",
                   $time, want.first_line, first_line);
          errors++;
        end
        if (repeat_count !== want.repeat_count) begin
          $display("%0t: repeat_count expected %0d actual %0d",
                   $time, want.repeat_count, repeat_count);
          errors++;
        end
        if (last_result !== want.last_result) begin
          $display("%0t: last_result expected %0d actual %0d",
                   $time, want.last_result, last_result);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    aldu_result_t t0, t1;
    int wait_cycles;
    idle_on = 1'b1;
    hold_request = 1'b0;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    byte_in = '0;
    end_of_input = 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      t0 = '{rows[i].f0, rows[i].c0, rows[i].n == 1};
      t1 = '{rows[i].f1, rows[i].c1, 1'b1};
      send_word(rows[i].b, rows[i].eoi, rows[i].n, t0, t1);
    end
    drain();

    // Long receiver hold-off while the sender keeps streaming. The request
    // stays up until the receiver, sampling at falling edges, surely sees it.
    hold_request = 1'b1;
    repeat (2) @(negedge clk);
    hold_request = 1'b0;
    random_stream(250);
    drain();

    set_regs(1, 0, 0, FILTER_SINGLE);
    idle_on = 1'b0;   // a stretch with no gaps on either side
    random_stream(250);
    idle_on = 1'b1;
    drain();

    set_regs(0, 2, 3, FILTER_REPEATED);
    random_stream(250);
    drain();

    // Largest settings; filter mode three behaves like mode zero.
    set_regs(255, 4095, 4095, 3);
    random_stream(200);
    drain();

    set_regs(2, 1, 1, 0);
    random_stream(250);
    drain();

    repeat (3) begin
      set_regs($urandom_range(4095), $urandom_range(4095) % 6,
               $urandom_range(4095), $urandom_range(4095));
      random_stream(100);
      drain();
    end

    wait_cycles = 0;
    while (pending_groups.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_groups.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
